### rtl/core/point_in_polygon_test_assert.svh
// assertion macros for the point in polygon test block
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// same-cycle implication
`define PIPT_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pipt assertion failed");

// next-cycle implication
`define PIPT_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pipt assertion failed");

`endif

### rtl/core/pipt_pkg.sv
// shared types, codes and helpers for the point in polygon test block
package pipt_pkg;

	localparam int COORD_W = 16;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0] diff_t;
	typedef logic signed [2*COORD_W+1:0] prod_t;
	typedef logic signed [2*COORD_W+2:0] cross_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	typedef enum logic [1:0] {
		TURN_COL = 2'd0,
		TURN_POS = 2'd1,
		TURN_NEG = 2'd2
	} turn_t;

	typedef struct packed {
		logic act;
		logic meet;
		logic coll;
		logic onbox;
	} edge_res_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_RAY_END_X    = 1'b1;

	function automatic diff_t sub(coord_t u, coord_t w);
		return diff_t'(u) - diff_t'(w);
	endfunction

	// q within the span of u and w
	function automatic logic between(coord_t q, coord_t u, coord_t w);
		return (q <= u || q <= w) && (q >= u || q >= w);
	endfunction

	function automatic turn_t turn_of(cross_t v);
		turn_t t;
		if (v == '0) begin
			t = TURN_COL;
		end else if (v > 0) begin
			t = TURN_POS;
		end else begin
			t = TURN_NEG;
		end
		return t;
	endfunction

	// turn of -(d1 * d2) from operand signs alone
	function automatic turn_t turn_neg_prod(diff_t d1, diff_t d2);
		turn_t t;
		if (d1 == '0 || d2 == '0) begin
			t = TURN_COL;
		end else if (d1[COORD_W] != d2[COORD_W]) begin
			t = TURN_POS;
		end else begin
			t = TURN_NEG;
		end
		return t;
	endfunction

endpackage

### rtl/core/point_in_polygon_test.sv
// point in polygon test by ray casting over a rotating ring of vertex cells
//
// input channel (in_valid/in_ready) takes one word per item: op selects a vertex
// load (vertex_index, coord_x, coord_y) or a query of point (coord_x, coord_y).
// a load is written in the cycle it is accepted and gives no result; loads go one per cycle
// while no query runs. a query rotates the whole ring once, one edge per cycle, then drains
// the two-stage edge test, so in_ready stays low until the result is registered and no
// new item is taken before the query is through. the ring length sets how long a query
// runs, whatever vertex_count says.
// out_valid/out_ready carries one inside_res word per query from an output
// register; loads are taken while a result waits, and a finished query holds in
// its final state until the receiver frees the output register.
// the config port (cfg_we, cfg_index, cfg_data) sets vertex_count and ray_end_x; the user
// must write it only while the block is idle, which the block itself does not enforce.
// reset clears control and the config registers (vertex_count 0, ray_end_x 1000);
// vertex cells hold garbage until loaded.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [5:0]              vertex_index,
	input  logic signed [15:0]      coord_x,
	input  logic signed [15:0]      coord_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    inside_res,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [15:0]             cfg_data
);
	import pipt_pkg::*;

	localparam int CW = ($clog2(MAX_VERTICES + 1) > 7) ? $clog2(MAX_VERTICES + 1) : 7;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t      state_q;
	logic [CW-1:0] step_q;
	logic        drain_q;
	logic [6:0]  vcount_q;
	coord_t      ray_x_q;
	vertex_t     p_q;
	vertex_t     v0_q;
	logic        few_q;
	logic        parity_q;
	logic        done_q;
	logic        hit_q;
	logic        out_valid_q;
	logic        out_res_q;

	vertex_t     cell_v [MAX_VERTICES];
	vertex_t     wdata;
	vertex_t     b_v;
	edge_res_t   res;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] neff;
	logic        acc_in;
	logic        shift;
	logic        active;
	logic        last;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;
	assign shift    = (state_q == ST_RUN);
	assign wdata    = '{x: coord_x, y: coord_y};
	assign cnt_ext  = CW'(vcount_q);
	assign neff     = (cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext;
	assign active   = shift && (step_q < neff);
	assign last     = (step_q == neff - CW'(1));
	assign b_v      = last ? v0_q : cell_v[1];

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		pipt_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.wr    (acc_in && op == OP_LOAD && CW'(vertex_index) == CW'(k)),
			.wdata (wdata),
			.nxt   (cell_v[(k + 1) % MAX_VERTICES]),
			.v     (cell_v[k])
		);
	end

	pipt_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.act    (active),
		.a      (cell_v[0]),
		.b      (b_v),
		.p      (p_q),
		.ex     (ray_x_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ray_x_q  <= 16'sd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vcount_q <= cfg_data[6:0];
				REG_RAY_END_X:    ray_x_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && op == OP_QUERY) begin
			p_q   <= wdata;
			v0_q  <= cell_v[0];
			few_q <= (neff < CW'(3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			drain_q     <= 1'b0;
			parity_q    <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_res_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			if (acc_in && op == OP_QUERY) begin
				parity_q <= 1'b0;
				done_q   <= 1'b0;
				hit_q    <= 1'b0;
			end else if (res.act && res.meet && !done_q) begin
				if (res.coll) begin
					done_q <= 1'b1;
					hit_q  <= res.onbox;
				end else begin
					parity_q <= ~parity_q;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && op == OP_QUERY) begin
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + CW'(1);
					if (step_q == CW'(MAX_VERTICES - 1)) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_res_q   <= few_q ? 1'b0 : (done_q ? hit_q : parity_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = out_res_q;

endmodule

### rtl/core/pipt_cell.sv
// one vertex cell of the rotating vertex ring
module pipt_cell (
	input  logic              clk,
	input  logic              shift,
	input  logic              wr,
	input  pipt_pkg::vertex_t wdata,
	input  pipt_pkg::vertex_t nxt,
	output pipt_pkg::vertex_t v
);
	import pipt_pkg::*;

	vertex_t v_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			v_q <= wdata;
		end else if (shift) begin
			v_q <= nxt;
		end
	end

	assign v = v_q;

endmodule

### rtl/core/pipt_edge.sv
// two-stage edge against ray crossing test
module pipt_edge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                act,
	input  pipt_pkg::vertex_t   a,
	input  pipt_pkg::vertex_t   b,
	input  pipt_pkg::vertex_t   p,
	input  pipt_pkg::coord_t    ex,
	output pipt_pkg::edge_res_t res
);
	import pipt_pkg::*;

	logic  act_s1;
	prod_t m1_s1, m2_s1, m3_s1;
	turn_t t3_s1, t4_s1;
	logic  bp_s1, be_s1, ba_s1, bb_s1;
	edge_res_t res_s2;

	diff_t dby, dbx, pxb, pyb, exb, dxe, dya, dyb;
	turn_t t1, t2;
	logic  meet;

	always_comb begin
		dby = sub(b.y, a.y);
		dbx = sub(b.x, a.x);
		pxb = sub(p.x, b.x);
		pyb = sub(p.y, b.y);
		exb = sub(ex, b.x);
		dxe = sub(ex, p.x);
		dya = sub(a.y, p.y);
		dyb = sub(b.y, p.y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= act;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1 <= dby * pxb;
		m2_s1 <= dbx * pyb;
		m3_s1 <= dby * exb;
		t3_s1 <= turn_neg_prod(dxe, dya);
		t4_s1 <= turn_neg_prod(dxe, dyb);
		bp_s1 <= between(p.x, a.x, b.x) && between(p.y, a.y, b.y);
		be_s1 <= between(ex, a.x, b.x) && between(p.y, a.y, b.y);
		ba_s1 <= between(a.x, p.x, ex) && (a.y == p.y);
		bb_s1 <= between(b.x, p.x, ex) && (b.y == p.y);
	end

	always_comb begin
		t1 = turn_of(cross_t'(m1_s1) - cross_t'(m2_s1));
		t2 = turn_of(cross_t'(m3_s1) - cross_t'(m2_s1));
		meet = (t1 != t2 && t3_s1 != t4_s1) ||
			(t1 == TURN_COL && bp_s1) || (t2 == TURN_COL && be_s1) ||
			(t3_s1 == TURN_COL && ba_s1) || (t4_s1 == TURN_COL && bb_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2.act   <= act_s1;
			res_s2.meet  <= meet;
			res_s2.coll  <= (t1 == TURN_COL);
			res_s2.onbox <= bp_s1;
		end
	end

	assign res = res_s2;

endmodule

### rtl/core/pipt_checker.sv
// port-level checks for the point in polygon test block, with its bind
`include "point_in_polygon_test_assert.svh"

module pipt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              op,
	input logic              out_valid,
	input logic              out_ready,
	input logic              inside_res
);
	import pipt_pkg::*;

	logic q_acc;

	assign q_acc = in_valid && in_ready && op == OP_QUERY;

	// a query holds off further input
	`PIPT_ASSERT_NXT(a_query_busy, clk, arst_n, q_acc, !in_ready)

	// a result appears only at the end of a query
	`PIPT_ASSERT_IMP(a_res_after_busy, clk, arst_n, $rose(out_valid), $past(!in_ready))

	// no result the cycle after a query starts with an empty output
	`PIPT_ASSERT_NXT(a_no_early_res, clk, arst_n, q_acc && !out_valid, !out_valid)

	// stalled result holds
	`PIPT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(inside_res))

endmodule

bind point_in_polygon_test pipt_checker u_pipt_checker (.*);

### tb/point_in_polygon_test_tb.sv
// self-checking testbench for the ray-casting point in polygon test block
module point_in_polygon_test_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pipt_pkg::*;

	localparam int NV = 64;
	localparam int ITEM_TARGET = 1050;
	localparam int WATCHDOG_LIMIT = 4000;

	class inside_scoreboard;
		longint vx[NV];
		longint vy[NV];
		int unsigned count_reg;
		longint ray_x;
		bit inside_q[$];
		int errors;

		function new();
			foreach (vx[i]) begin
				vx[i] = 0;
				vy[i] = 0;
			end
			count_reg = 0;
			ray_x = 1000;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(logic idx, logic [15:0] d);
			if (idx == REG_VERTEX_COUNT) begin
				count_reg = d[6:0];
			end else begin
				ray_x = longint'($signed(d));
			end
		endfunction

		function turn_t orient(longint px, longint py, longint qx, longint qy,
				longint rx, longint ry);
			longint v;
			v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
			if (v == 0) return TURN_COL;
			return (v > 0) ? TURN_POS : TURN_NEG;
		endfunction

		function bit in_span(longint px, longint py, longint qx, longint qy,
				longint rx, longint ry);
			return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
				qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
		endfunction

		function bit crosses(longint ax, longint ay, longint bx, longint by,
				longint cx, longint cy, longint dx, longint dy);
			turn_t t1, t2, t3, t4;
			t1 = orient(ax, ay, bx, by, cx, cy);
			t2 = orient(ax, ay, bx, by, dx, dy);
			t3 = orient(cx, cy, dx, dy, ax, ay);
			t4 = orient(cx, cy, dx, dy, bx, by);
			if (t1 != t2 && t3 != t4) return 1;
			if (t1 == TURN_COL && in_span(ax, ay, cx, cy, bx, by)) return 1;
			if (t2 == TURN_COL && in_span(ax, ay, dx, dy, bx, by)) return 1;
			if (t3 == TURN_COL && in_span(cx, cy, ax, ay, dx, dy)) return 1;
			if (t4 == TURN_COL && in_span(cx, cy, bx, by, dx, dy)) return 1;
			return 0;
		endfunction

		function bit point_inside(longint px, longint py);
			int n, j, hits;
			n = (count_reg > NV) ? NV : count_reg;
			hits = 0;
			if (n < 3) return 0;
			for (int i = 0; i < n; i++) begin
				j = (i + 1 == n) ? 0 : i + 1;
				if (crosses(vx[i], vy[i], vx[j], vy[j], px, py, ray_x, py)) begin
					if (orient(vx[i], vy[i], px, py, vx[j], vy[j]) == TURN_COL)
						return in_span(vx[i], vy[i], px, py, vx[j], vy[j]);
					hits++;
				end
			end
			return hits[0];
		endfunction

		function void note_word(logic o, logic [5:0] idx, logic signed [15:0] x,
				logic signed [15:0] y);
			if (o == OP_LOAD) begin
				vx[idx] = x;
				vy[idx] = y;
			end else begin
				inside_q = {inside_q, point_inside(x, y)};
			end
		endfunction

		task check_word(logic res);
			bit exp_res;
			if (inside_q.size() == 0) begin
				report("result word with none expected");
			end else begin
				exp_res = inside_q.pop_front();
				if (res !== exp_res)
					report($sformatf("inside_res got %b want %b", res, exp_res));
			end
		endtask

		function int pending();
			return inside_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic op = OP_LOAD;
	logic [5:0] vertex_index = '0;
	logic signed [15:0] coord_x = '0;
	logic signed [15:0] coord_y = '0;
	logic out_valid;
	logic out_ready = 0;
	logic inside_res;
	logic cfg_we = 0;
	logic cfg_index = REG_VERTEX_COUNT;
	logic [15:0] cfg_data = '0;

	inside_scoreboard sb = new();
	int items_sent = 0;
	bit quiet = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	longint poly_x[NV];
	longint poly_y[NV];

	point_in_polygon_test #(.MAX_VERTICES(NV)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vertex_index(vertex_index), .coord_x(coord_x), .coord_y(coord_y),
		.out_valid(out_valid), .out_ready(out_ready), .inside_res(inside_res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			out_ready = 0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready = 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(inside_res);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("point_in_polygon_test regression: fail");
				$finish;
			end
		end
	end

	task send(logic o, logic [5:0] idx, logic signed [15:0] x, logic signed [15:0] y);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 0;
			end
		end
		@(negedge clk);
		in_valid = 1;
		op = o;
		vertex_index = idx;
		coord_x = x;
		coord_y = y;
		do @(posedge clk); while (!in_ready);
		sb.note_word(o, idx, x, y);
		items_sent++;
		if (items_sent > ITEM_TARGET - 150) quiet = 1;
	endtask

	task settle();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (NV + 8) @(posedge clk);
	endtask

	task write_reg(logic idx, logic [15:0] d);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 0;
		sb.set_reg(idx, d);
	endtask

	function logic signed [15:0] pick_coord(bit wide, int span);
		if (wide) return 16'($urandom);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	task run_phase();
		int n, m, sel, nq, k, span;
		bit wide;
		logic [15:0] cd;
		logic signed [15:0] qx, qy;
		sel = $urandom_range(0, 19);
		if (sel < 2) n = $urandom_range(0, 2);
		else if (sel < 17) n = $urandom_range(3, 12);
		else if (sel == 17) n = NV;
		else n = $urandom_range(NV, 127);
		wide = ($urandom_range(0, 4) == 0);
		span = $urandom_range(4, 40);
		settle();
		cd = 16'($urandom);
		cd[6:0] = 7'(n);
		write_reg(REG_VERTEX_COUNT, cd);
		case ($urandom_range(0, 5))
			0: cd = 16'h8000;
			1: cd = 16'h7fff;
			2: cd = 16'($urandom);
			default: cd = pick_coord(0, 3 * span);
		endcase
		write_reg(REG_RAY_END_X, cd);
		m = (n > NV) ? NV : n;
		for (int i = 0; i < m; i++) begin
			poly_x[i] = pick_coord(wide, span);
			poly_y[i] = pick_coord(wide, span);
			send(OP_LOAD, 6'(i), 16'(poly_x[i]), 16'(poly_y[i]));
		end
		nq = $urandom_range(8, 30);
		for (int q = 0; q < nq; q++) begin
			sel = $urandom_range(0, 9);
			k = (m > 0) ? $urandom_range(0, m - 1) : 0;
			if (sel == 0) begin
				k = $urandom_range(0, NV - 1);
				qx = pick_coord(wide, span);
				qy = pick_coord(wide, span);
				send(OP_LOAD, 6'(k), qx, qy);
				if (k < NV) begin
					poly_x[k] = qx;
					poly_y[k] = qy;
				end
			end else if (sel == 1 && m > 0) begin
				send(OP_QUERY, 6'($urandom), 16'(poly_x[k]), 16'(poly_y[k]));
			end else if (sel == 2) begin
				send(OP_QUERY, 6'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				send(OP_QUERY, 6'($urandom), pick_coord(wide, span), pick_coord(wide, span));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// square, ray to the right
		send(OP_LOAD, 0, 0, 0);
		send(OP_LOAD, 1, 10, 0);
		send(OP_LOAD, 2, 10, 10);
		send(OP_LOAD, 3, 0, 10);
		send(OP_QUERY, 0, 5, 5);
		settle();
		write_reg(REG_VERTEX_COUNT, 4);
		send(OP_QUERY, 0, 5, 5);
		send(OP_QUERY, 6'h3f, 15, 5);
		send(OP_QUERY, 0, 0, 5);
		send(OP_QUERY, 0, 10, 10);
		send(OP_QUERY, 0, 5, 0);
		send(OP_QUERY, 0, -5, 5);
		send(OP_QUERY, 0, 5, 10);
		// ray pointing left
		settle();
		write_reg(REG_RAY_END_X, 16'hfc18);
		send(OP_QUERY, 0, 5, 5);
		send(OP_QUERY, 0, 20, 5);
		send(OP_QUERY, 0, -20, 5);
		// extreme coordinates
		send(OP_LOAD, 0, 16'sh8000, 16'sh8000);
		send(OP_LOAD, 1, 16'sh7fff, 16'sh8000);
		send(OP_LOAD, 2, 16'sh7fff, 16'sh7fff);
		send(OP_LOAD, 3, 16'sh8000, 16'sh7fff);
		send(OP_QUERY, 0, 0, 0);
		send(OP_QUERY, 0, 16'sh7fff, 16'sh7fff);
		send(OP_QUERY, 0, 16'sh8000, 0);
		settle();
		write_reg(REG_RAY_END_X, 16'h7fff);
		send(OP_QUERY, 0, 0, 0);
		send(OP_QUERY, 0, 16'sh8000, 16'sh8000);
		// too few vertices
		settle();
		write_reg(REG_VERTEX_COUNT, 2);
		send(OP_QUERY, 0, 1, 1);
		while (items_sent < ITEM_TARGET) run_phase();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (NV + 8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("point_in_polygon_test regression: pass");
		end else begin
			$display("point_in_polygon_test regression: fail");
		end
		$finish;
	end
endmodule
